// ----- design/ppst_pkg.sv -----
// Pure pursuit steering: shared types, state codes and fixed-point constants.
// No dependencies; imported by every module of the block.
package ppst_pkg;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_POSE = 1'b1;

   localparam logic [1:0] CSR_LOOKAHEAD = 2'd0;
   localparam logic [1:0] CSR_GAIN      = 2'd1;
   localparam logic [1:0] CSR_COUNT     = 2'd2;
   localparam logic [1:0] CSR_NEARLIM   = 2'd3;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = 33;
   localparam int HEAD_W  = 33;
   localparam int TRIG_W  = 17;
   localparam int D2_W    = 66;
   localparam int L2_W    = 46;
   localparam int PART_W  = 50;
   localparam int DELY_W  = 51;
   localparam int PROD_W  = 67;
   localparam int QUOT_W  = 25;
   localparam int STEER_W = 24;
   localparam int ROOT_W  = 32;
   localparam int TRIG_SHIFT = 15;

   localparam logic signed [HEAD_W-1:0] HALF_Q30  = 33'sd536870912;
   localparam logic signed [TRIG_W-1:0] TRIG_ONE  = 17'sd32768;
   localparam logic [QUOT_W-1:0]        SAT_POS   = 25'h07FFFFF;
   localparam logic [QUOT_W-1:0]        SAT_NEG   = 25'h0800000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQUARE, ST_ROOT_GO, ST_ROOT_WAIT,
      ST_DIVC_GO, ST_DIVC_WAIT, ST_DIVS_GO, ST_DIVS_WAIT,
      ST_READ, ST_DIFF, ST_MUL, ST_SUM, ST_EVAL,
      ST_PROD, ST_DELY, ST_GAIN, ST_DIVST_GO, ST_DIVST_WAIT, ST_FINISH
   } ppst_state_type;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
   } ppst_div_res_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } ppst_sqrt_res_type;

endpackage

// ----- design/pure_pursuit_steering_unit.sv -----
// Pure pursuit steering top level: sequencer, datapath and unit instances.
// Depends on ppst_pkg, ppst_wpmem, ppst_sqrt and ppst_div.
//
// Usage: req_ carries either a waypoint load (req_operation = load), written
// into the table in the transfer cycle and answered by nothing, or a pose,
// answered by exactly one rsp_ transfer (steer, goal index, stalled flag).
// csr_ writes set lookahead, gain, waypoint count and the nearest-search
// limit; they take effect at once. The user must make them only while the
// block is idle; the block itself does not enforce this. A pose computes the
// heading (square root plus two 25-step divides), on the first pose after
// reset searches all waypoints for the nearest one, then walks to the
// lookahead target, each waypoint through the table read and squared-distance
// pipeline, and, if a target is found, runs the final steering divide. Reset
// clears the goal pointer and the located flag and sets the config registers
// to defaults; the waypoint table keeps no reset value. A finished result
// waits in the output register while the receiver stalls; the next item is
// accepted meanwhile and its result is held back until that register frees up.
module pure_pursuit_steering_unit #(
   parameter int MAX_WAYPOINTS   = 1024,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [9:0]          req_wp_index,
   input  logic signed [31:0]  req_coord_x,
   input  logic signed [31:0]  req_coord_y,
   input  logic signed [15:0]  req_quat_w,
   input  logic signed [15:0]  req_quat_x,
   input  logic signed [15:0]  req_quat_y,
   input  logic signed [15:0]  req_quat_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [23:0]  rsp_steer_value,
   output logic [9:0]          rsp_goal_index,
   output logic                rsp_stalled,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [30:0]         csr_wdata
);
   import ppst_pkg::*;

   localparam int AW     = $clog2(MAX_WAYPOINTS);
   localparam int CW     = AW + 1;
   localparam int NUM_W  = PROD_W + COORD_FRAC_BITS - 6;
   localparam int GSHIFT = COORD_FRAC_BITS - 6;

   ppst_state_type state_ff, state_in;

   logic [22:0] look_ff, look_in;
   logic [15:0] gain_ff, gain_in;
   logic [10:0] count_ff, count_in;
   logic [30:0] nlim_ff, nlim_in;

   logic                      located_ff, located_in, near_ff, near_in;
   logic [AW-1:0]             goal_ff, goal_in;
   logic [CW-1:0]             k_ff, k_in, n_ff, n_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [HEAD_W-1:0]  s_ff, s_in, c_ff, c_in;
   logic [63:0]               ss2_ff, ss2_in, cc2_ff, cc2_in;
   logic [L2_W-1:0]           l2_ff, l2_in;
   logic signed [TRIG_W-1:0]  cs_ff, cs_in, sn_ff, sn_in;
   logic signed [DIFF_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [D2_W-1:0]           ax2_ff, ax2_in, ay2_ff, ay2_in, d2_ff, d2_in, lim_ff, lim_in;
   logic signed [PART_W-1:0]  p1_ff, p1_in, p2_ff, p2_in;
   logic signed [DELY_W-1:0]  dely_ff, dely_in;
   logic [PROD_W-1:0]         gprod_ff, gprod_in;
   logic                      neg_ff, neg_in;
   logic signed [STEER_W-1:0] steer_ff, steer_in;
   logic                      stalled_ff, stalled_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [STEER_W-1:0] out_steer_ff, out_steer_in;
   logic [9:0]                out_goal_ff, out_goal_in;
   logic                      out_stalled_ff, out_stalled_in;

   logic                   accept, mem_we;
   logic [2*COORD_W-1:0]   rd_data;
   logic [AW-1:0]          rd_addr;
   logic                   sqrt_start, div_start;
   logic [NUM_W-1:0]       div_num;
   logic [D2_W-1:0]        div_den;
   ppst_sqrt_res_type      sqrt_res;
   ppst_div_res_type       div_res;

   logic signed [31:0]     pwz, pxy, pyy, pzz;
   logic [CW-1:0]          n_new, goal_next;
   logic [DIFF_W-1:0]      ax, ay, cmag, smag;
   logic [DELY_W-1:0]      dmag;
   logic [QUOT_W-1:0]      sat, qsat;
   logic [TRIG_W-1:0]      q17;
   logic signed [COORD_W-1:0] wx, wy;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign mem_we    = accept && (req_operation == OP_LOAD) &&
                      (32'(req_wp_index) < MAX_WAYPOINTS);
   assign rd_addr   = near_ff ? k_ff[AW-1:0] : goal_ff;
   assign wx        = rd_data[2*COORD_W-1:COORD_W];
   assign wy        = rd_data[COORD_W-1:0];

   ppst_wpmem #(.DEPTH(MAX_WAYPOINTS), .AW(AW)) u_mem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (AW'(req_wp_index)),
      .wr_data    ({req_coord_x, req_coord_y}),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   ppst_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (ss2_ff + cc2_ff),
      .res     (sqrt_res)
   );

   ppst_div #(.NUM_W(NUM_W), .DEN_W(D2_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .res   (div_res)
   );

   always_comb begin
      look_in  = look_ff;
      gain_in  = gain_ff;
      count_in = count_ff;
      nlim_in  = nlim_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LOOKAHEAD: look_in  = csr_wdata[22:0];
            CSR_GAIN:      gain_in  = csr_wdata[15:0];
            CSR_COUNT:     count_in = csr_wdata[10:0];
            CSR_NEARLIM:   nlim_in  = csr_wdata;
            default:       ;
         endcase
      end
   end

   always_comb begin
      pwz   = req_quat_w * req_quat_z;
      pxy   = req_quat_x * req_quat_y;
      pyy   = req_quat_y * req_quat_y;
      pzz   = req_quat_z * req_quat_z;
      n_new = (32'(count_ff) > MAX_WAYPOINTS) ? CW'(MAX_WAYPOINTS) : CW'(count_ff);
      goal_next = CW'(goal_ff) + 1'b1;
      ax    = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
      ay    = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);
      cmag  = c_ff[HEAD_W-1] ? HEAD_W'(-c_ff) : HEAD_W'(c_ff);
      smag  = s_ff[HEAD_W-1] ? HEAD_W'(-s_ff) : HEAD_W'(s_ff);
      dmag  = dely_ff[DELY_W-1] ? DELY_W'(-dely_ff) : DELY_W'(dely_ff);
      sat   = neg_ff ? SAT_NEG : SAT_POS;
      qsat  = (div_res.ovf || (div_res.quot > sat)) ? sat : div_res.quot;
      q17   = div_res.quot[TRIG_W-1:0];

      state_in   = state_ff;
      located_in = located_ff;
      near_in    = near_ff;
      goal_in    = goal_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      s_in       = s_ff;
      c_in       = c_ff;
      ss2_in     = ss2_ff;
      cc2_in     = cc2_ff;
      l2_in      = l2_ff;
      cs_in      = cs_ff;
      sn_in      = sn_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      ax2_in     = ax2_ff;
      ay2_in     = ay2_ff;
      d2_in      = d2_ff;
      lim_in     = lim_ff;
      p1_in      = p1_ff;
      p2_in      = p2_ff;
      dely_in    = dely_ff;
      gprod_in   = gprod_ff;
      neg_in     = neg_ff;
      steer_in   = steer_ff;
      stalled_in = stalled_ff;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      out_steer_in   = out_steer_ff;
      out_goal_in    = out_goal_ff;
      out_stalled_in = out_stalled_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_POSE)) begin
               px_in      = req_coord_x;
               py_in      = req_coord_y;
               s_in       = HEAD_W'(pwz) + HEAD_W'(pxy);
               c_in       = HALF_Q30 - HEAD_W'(pyy) - HEAD_W'(pzz);
               n_in       = n_new;
               steer_in   = '0;
               stalled_in = 1'b1;
               lim_in     = D2_W'(nlim_ff) << COORD_FRAC_BITS;
               near_in    = !located_ff;
               k_in       = '0;
               if (n_new == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  if (CW'(goal_ff) >= n_new) begin
                     goal_in = '0;
                  end
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            ss2_in   = $unsigned(64'(s_ff) * 64'(s_ff));
            cc2_in   = $unsigned(64'(c_ff) * 64'(c_ff));
            l2_in    = L2_W'(look_ff) * L2_W'(look_ff);
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (sqrt_res.done) begin
               if (sqrt_res.root == '0) begin
                  cs_in    = TRIG_ONE;
                  sn_in    = '0;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DIVC_GO;
               end
            end
         end
         ST_DIVC_GO: begin
            div_start = 1'b1;
            div_num   = NUM_W'(cmag) << TRIG_SHIFT;
            div_den   = D2_W'(sqrt_res.root);
            state_in  = ST_DIVC_WAIT;
         end
         ST_DIVC_WAIT: begin
            if (div_res.done) begin
               cs_in    = c_ff[HEAD_W-1] ? -$signed(q17) : $signed(q17);
               state_in = ST_DIVS_GO;
            end
         end
         ST_DIVS_GO: begin
            div_start = 1'b1;
            div_num   = NUM_W'(smag) << TRIG_SHIFT;
            div_den   = D2_W'(sqrt_res.root);
            state_in  = ST_DIVS_WAIT;
         end
         ST_DIVS_WAIT: begin
            if (div_res.done) begin
               sn_in    = s_ff[HEAD_W-1] ? -$signed(q17) : $signed(q17);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dx_in    = DIFF_W'(wx) - DIFF_W'(px_ff);
            dy_in    = DIFF_W'(wy) - DIFF_W'(py_ff);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            ax2_in   = D2_W'(ax) * D2_W'(ax);
            ay2_in   = D2_W'(ay) * D2_W'(ay);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            d2_in    = ax2_ff + ay2_ff;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            k_in     = k_ff + 1'b1;
            state_in = ST_READ;
            if (near_ff) begin
               if (d2_ff < lim_ff) begin
                  lim_in  = d2_ff;
                  goal_in = k_ff[AW-1:0];
               end
               if (k_ff + 1'b1 == n_ff) begin
                  located_in = 1'b1;
                  near_in    = 1'b0;
                  k_in       = '0;
               end
            end else if (d2_ff >= D2_W'(l2_ff)) begin
               stalled_in = 1'b0;
               state_in   = ST_PROD;
            end else begin
               goal_in = (goal_next >= n_ff) ? '0 : goal_next[AW-1:0];
               if (k_ff + 1'b1 == n_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PROD: begin
            p1_in    = PART_W'(dy_ff) * PART_W'(cs_ff);
            p2_in    = PART_W'(dx_ff) * PART_W'(sn_ff);
            state_in = ST_DELY;
         end
         ST_DELY: begin
            dely_in  = DELY_W'(p1_ff) - DELY_W'(p2_ff);
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            neg_in   = dely_ff[DELY_W-1];
            gprod_in = PROD_W'(gain_ff) * PROD_W'(dmag);
            if ((dely_ff == '0) || (d2_ff == '0)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIVST_GO;
            end
         end
         ST_DIVST_GO: begin
            div_start = 1'b1;
            div_num   = NUM_W'(gprod_ff) << GSHIFT;
            div_den   = d2_ff;
            state_in  = ST_DIVST_WAIT;
         end
         ST_DIVST_WAIT: begin
            if (div_res.done) begin
               steer_in = neg_ff ? -$signed(STEER_W'(qsat)) : $signed(STEER_W'(qsat));
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               out_steer_in   = steer_ff;
               out_goal_in    = 10'(goal_ff);
               out_stalled_in = stalled_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         look_ff      <= 23'd78643;
         gain_ff      <= 16'd256;
         count_ff     <= 11'd0;
         nlim_ff      <= 31'd6553600;
         located_ff   <= 1'b0;
         near_ff      <= 1'b0;
         goal_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         look_ff      <= look_in;
         gain_ff      <= gain_in;
         count_ff     <= count_in;
         nlim_ff      <= nlim_in;
         located_ff   <= located_in;
         near_ff      <= near_in;
         goal_ff      <= goal_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff           <= k_in;
      n_ff           <= n_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      s_ff           <= s_in;
      c_ff           <= c_in;
      ss2_ff         <= ss2_in;
      cc2_ff         <= cc2_in;
      l2_ff          <= l2_in;
      cs_ff          <= cs_in;
      sn_ff          <= sn_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      ax2_ff         <= ax2_in;
      ay2_ff         <= ay2_in;
      d2_ff          <= d2_in;
      lim_ff         <= lim_in;
      p1_ff          <= p1_in;
      p2_ff          <= p2_in;
      dely_ff        <= dely_in;
      gprod_ff       <= gprod_in;
      neg_ff         <= neg_in;
      steer_ff       <= steer_in;
      stalled_ff     <= stalled_in;
      out_steer_ff   <= out_steer_in;
      out_goal_ff    <= out_goal_in;
      out_stalled_ff <= out_stalled_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_steer_value = out_steer_ff;
   assign rsp_goal_index  = out_goal_ff;
   assign rsp_stalled     = out_stalled_ff;

endmodule

// ----- design/ppst_wpmem.sv -----
// Waypoint table: one synchronous RAM holding {x, y} per slot, registered read.
// Depends on ppst_pkg for coordinate width.
module ppst_wpmem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [2*ppst_pkg::COORD_W-1:0]  wr_data,
   input  logic [AW-1:0]                   rd_addr,
   output logic [2*ppst_pkg::COORD_W-1:0]  rd_data_ff
);
   import ppst_pkg::*;

   logic [2*COORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ----- design/ppst_sqrt.sv -----
// Bit-serial integer square root of a 64-bit value; a new start restarts it.
// Depends on ppst_pkg for the result struct.
module ppst_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [63:0]                   operand,
   output ppst_pkg::ppst_sqrt_res_type   res
);
   import ppst_pkg::*;

   logic [63:0] v_ff, v_in, root_ff, root_in, bit_ff, bit_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] trial;

   always_comb begin
      trial   = root_ff + bit_ff;
      v_in    = v_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = operand;
         root_in = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in    = v_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff    <= v_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign res.done = done_ff;
   assign res.root = root_ff[ROOT_W-1:0];

endmodule

// ----- design/ppst_div.sv -----
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// Depends on ppst_pkg for the result struct and quotient width.
module ppst_div #(
   parameter int NUM_W = 77,
   parameter int DEN_W = 66
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            num,
   input  logic [DEN_W-1:0]            den,
   output ppst_pkg::ppst_div_res_type  res
);
   import ppst_pkg::*;

   localparam int CMP_W = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;
   localparam int CNT_W = $clog2(QUOT_W);

   logic [DEN_W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [QUOT_W-1:0] low_ff, low_in, quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in, ovf_ff, ovf_in;
   logic [DEN_W:0]    trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, low_ff[QUOT_W-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = DEN_W'(num >> QUOT_W);
         den_in  = den;
         low_in  = num[QUOT_W-1:0];
         quo_in  = '0;
         cnt_in  = CNT_W'(QUOT_W - 1);
         busy_in = 1'b1;
         ovf_in  = CMP_W'(num) >= (CMP_W'(den) << QUOT_W);
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUOT_W-2:0], fits};
         low_in = low_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
   end

   assign res.done = done_ff;
   assign res.ovf  = ovf_ff;
   assign res.quot = quo_ff;

endmodule

// ----- design/ppst_checker.sv -----
// Port-level checks for the pure pursuit steering unit, bound to the top level.
// Depends on ppst_pkg for the operation codes.
module ppst_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_operation,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [23:0] rsp_steer_value,
   input logic [9:0]         rsp_goal_index,
   input logic               rsp_stalled
);
   import ppst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_steer_value) &&
      $stable(rsp_goal_index) && $stable(rsp_stalled))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stalled |-> rsp_steer_value == 24'sd0)
      else $error("stalled result with nonzero steer");

   a_pose_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_POSE |=> !req_ready)
      else $error("ready right after pose transfer");

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_LOAD |=> req_ready)
      else $error("not ready after load transfer");

endmodule

bind pure_pursuit_steering_unit ppst_checker u_ppst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_steer_value (rsp_steer_value),
   .rsp_goal_index  (rsp_goal_index),
   .rsp_stalled     (rsp_stalled)
);

// ----- sim/testbench.sv -----
// Testbench for pure_pursuit_steering_unit: directed and random waypoint loads and poses.
// Expected steering results come from a behavioral predictor inside this file.
// Depends on ppst_pkg and the design sources.
module testbench;
   import ppst_pkg::*;

   typedef struct {
      logic               op;
      logic [9:0]         idx;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] qw;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
   } steer_req_type;

   typedef struct {
      logic [23:0] steer;
      logic [9:0]  goal;
      logic        stalled;
   } steer_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_operation = OP_LOAD;
   logic [9:0]         req_wp_index = '0;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [15:0] req_quat_w = '0;
   logic signed [15:0] req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_steer_value;
   logic [9:0]         rsp_goal_index;
   logic               rsp_stalled;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = CSR_LOOKAHEAD;
   logic [30:0]        csr_wdata = '0;

   steer_req_type req_q[$];
   steer_rsp_type steer_exp_q[$];
   steer_req_type cur_req;
   int            send_idle_pct = 25;
   int            recv_idle_pct = 49;
   int            mismatches = 0;
   int            sent_items = 0;

   // predictor state
   logic signed [31:0] wp_x[1024];
   logic signed [31:0] wp_y[1024];
   int                 goal_ptr = 0;
   bit                 located = 1'b0;
   logic [22:0]        lookahead = 23'd78643;
   logic [15:0]        gain = 16'd256;
   logic [10:0]        wp_count = 11'd0;
   logic [30:0]        near_lim = 31'd6553600;

   // generator bookkeeping
   bit gen_written[1024];

   pure_pursuit_steering_unit DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [127:0] dist_sq(int k, longint px, longint py);
      longint dx, dy;
      logic [127:0] ax, ay;
      dx = longint'(wp_x[k]) - px;
      dy = longint'(wp_y[k]) - py;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      return ax * ax + ay * ay;
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   task automatic predict_steering(input steer_req_type it);
      longint px, py, s, c, cs, ss, dx, dy, dely, r;
      int n, k;
      logic [127:0] limw, l2, d2, num, q, lim;
      logic [63:0] sum;
      bit found;
      steer_rsp_type res;
      px = it.x;
      py = it.y;
      found = 0;
      res.steer = '0;
      res.stalled = 1'b1;
      if (it.op == OP_LOAD) begin
         wp_x[it.idx] = it.x;
         wp_y[it.idx] = it.y;
         return;
      end
      n = (wp_count > 1024) ? 1024 : wp_count;
      if (n != 0) begin
         s = longint'(it.qw) * it.qz + longint'(it.qx) * it.qy;
         c = 64'sd536870912 - (longint'(it.qy) * it.qy + longint'(it.qz) * it.qz);
         sum = s * s + c * c;
         r = root64(sum);
         if (r == 0) begin
            cs = 32768;
            ss = 0;
         end else begin
            cs = (c * 32768) / r;
            ss = (s * 32768) / r;
         end
         if (goal_ptr >= n) goal_ptr = 0;
         if (!located) begin
            limw = 128'(near_lim) << 16;
            for (k = 0; k < n; k++) begin
               d2 = dist_sq(k, px, py);
               if (d2 < limw) begin
                  limw = d2;
                  goal_ptr = k;
               end
            end
            located = 1'b1;
         end
         l2 = 128'(lookahead) * 128'(lookahead);
         for (k = 0; k < n; k++) begin
            if (dist_sq(goal_ptr, px, py) >= l2) begin
               found = 1;
               break;
            end
            goal_ptr = (goal_ptr + 1 >= n) ? 0 : goal_ptr + 1;
         end
         if (found) begin
            d2 = dist_sq(goal_ptr, px, py);
            dx = longint'(wp_x[goal_ptr]) - px;
            dy = longint'(wp_y[goal_ptr]) - py;
            res.stalled = 1'b0;
            dely = dy * cs - dx * ss;
            if (d2 != 0 && dely != 0) begin
               num = (128'(gain) * 128'((dely < 0) ? -dely : dely)) << 10;
               q = num / d2;
               lim = (dely < 0) ? 128'd8388608 : 128'd8388607;
               if (q > lim) q = lim;
               res.steer = (dely < 0) ? 24'(-q) : 24'(q);
            end
         end
      end
      res.goal = 10'(goal_ptr);
      steer_exp_q.insert(steer_exp_q.size(), res);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_steering(cur_req);
         if (!req_valid || req_ready) begin
            if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = req_q.pop_front();
               req_operation <= cur_req.op;
               req_wp_index <= cur_req.idx;
               req_coord_x <= cur_req.x;
               req_coord_y <= cur_req.y;
               req_quat_w <= cur_req.qw;
               req_quat_x <= cur_req.qx;
               req_quat_y <= cur_req.qy;
               req_quat_z <= cur_req.qz;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      steer_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (steer_exp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transfer: steer %h goal %0d stalled %b",
                           rsp_steer_value, rsp_goal_index, rsp_stalled);
            end else begin
               e = steer_exp_q.pop_front();
               if (rsp_steer_value !== e.steer || rsp_goal_index !== e.goal ||
                   rsp_stalled !== e.stalled) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: steer %h/%h goal %0d/%0d stalled %b/%b (exp/act)",
                              e.steer, rsp_steer_value, e.goal, rsp_goal_index,
                              e.stalled, rsp_stalled);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic int near_coord();
      return int'($urandom_range(2097152)) - 1048576;
   endfunction

   task automatic push_load(int k, logic signed [31:0] x, logic signed [31:0] y);
      steer_req_type it;
      it.op = OP_LOAD;
      it.idx = 10'(k);
      it.x = x;
      it.y = y;
      it.qw = 16'($urandom);
      it.qx = 16'($urandom);
      it.qy = 16'($urandom);
      it.qz = 16'($urandom);
      gen_written[k] = 1'b1;
      sent_items++;
      req_q.insert(req_q.size(), it);
   endtask

   task automatic push_pose(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [15:0] qw, logic signed [15:0] qx,
                            logic signed [15:0] qy, logic signed [15:0] qz);
      steer_req_type it;
      it.op = OP_POSE;
      it.idx = 10'($urandom);
      it.x = x;
      it.y = y;
      it.qw = qw;
      it.qx = qx;
      it.qy = qy;
      it.qz = qz;
      sent_items++;
      req_q.insert(req_q.size(), it);
   endtask

   task automatic fill_table(int n);
      for (int k = 0; k < n && k < 1024; k++)
         if (!gen_written[k]) push_load(k, near_coord(), near_coord());
   endtask

   task automatic wait_idle();
      while (req_q.size() != 0 || req_valid || steer_exp_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [30:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_LOOKAHEAD: lookahead = val[22:0];
         CSR_GAIN:      gain = val[15:0];
         CSR_COUNT:     wp_count = val[10:0];
         CSR_NEARLIM:   near_lim = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int n, sel;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part
      push_pose(0, 0, 16'sd32767, 0, 0, 0);
      for (int k = 0; k < 8; k++) push_load(k, k * 65536, (k % 2) * 32768);
      push_load(1023, 32'sh80000000, 32'sh7FFFFFFF);
      wait_idle();
      write_csr(CSR_COUNT, 31'd8);
      push_pose(0, 0, 16'sd32767, 0, 0, 0);
      push_pose(65536, 0, 16'sd1, -16'sd1, 16'sd16384, 16'sd16384);
      push_pose(32'sh80000000, 32'sh7FFFFFFF, -16'sd32768, -16'sd32768, -16'sd32768,
                -16'sd32768);
      push_pose(32'sh7FFFFFFF, 32'sh80000000, 16'sd32767, 16'sd32767, 16'sd32767,
                16'sd32767);
      push_pose(196608, 65536, 16'sd23170, 0, 0, 16'sd23170);
      wait_idle();
      write_csr(CSR_LOOKAHEAD, 31'd0);
      write_csr(CSR_GAIN, 31'd65535);
      write_csr(CSR_COUNT, 31'd1);
      push_pose(0, 0, 16'sd32767, 0, 0, 0);
      push_pose(1000, -3000, 16'sd32767, 0, 0, 0);
      wait_idle();
      write_csr(CSR_LOOKAHEAD, 31'd4194304);
      write_csr(CSR_COUNT, 31'd8);
      write_csr(CSR_NEARLIM, 31'h7FFFFFFF);
      push_pose(65536, 65536, 16'sd32767, 0, 0, 0);
      wait_idle();
      write_csr(CSR_LOOKAHEAD, 31'd1);
      write_csr(CSR_GAIN, 31'd0);
      write_csr(CSR_NEARLIM, 31'd0);
      push_pose(-65536, 0, 16'sd32767, 0, 0, 0);
      wait_idle();

      // random part
      while (sent_items < 275) begin
         if (sent_items < 97) begin
            send_idle_pct = 25;
            recv_idle_pct = 49;
         end else if (sent_items < 194) begin
            send_idle_pct = 49;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         n = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
         fill_table(n);
         wait_idle();
         write_csr(CSR_COUNT, 31'(n));
         sel = $urandom_range(9);
         write_csr(CSR_LOOKAHEAD, (sel == 0) ? 31'd0 : (sel == 1) ? 31'd4194304 :
                                  31'($urandom_range(262144)));
         sel = $urandom_range(9);
         write_csr(CSR_GAIN, (sel == 0) ? 31'd0 : (sel == 1) ? 31'd65535 :
                             31'($urandom_range(65535)));
         write_csr(CSR_NEARLIM, 31'($urandom));
         repeat ($urandom_range(8, 12)) begin
            sel = $urandom_range(99);
            if (sel < 70)
               push_pose(near_coord(), near_coord(), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
            else if (sel < 85)
               push_load($urandom_range(n - 1), near_coord(), near_coord());
            else if (sel < 95)
               push_load($urandom_range(1023), $urandom, $urandom);
            else
               push_pose($urandom, $urandom, 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
         end
         wait_idle();
      end

      repeat (200) @(posedge clock);
      if (steer_exp_q.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("PASS pure_pursuit_steering_unit");
      else
         $display("FAIL pure_pursuit_steering_unit");
      $finish;
   end

   initial begin
      #40000000;
      $display("FAIL pure_pursuit_steering_unit");
      $finish;
   end

endmodule

// ----- pure_pursuit_steering_unit.f -----
design/ppst_pkg.sv
design/ppst_wpmem.sv
design/ppst_sqrt.sv
design/ppst_div.sv
design/pure_pursuit_steering_unit.sv
design/ppst_checker.sv
sim/testbench.sv
